// File: src/ede_pkg.sv
// Shared types and constants for the edit distance engine.
// No dependencies; imported by ede_cell and edit_distance_engine_core.
package ede_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int SYM_W       = 8;
    localparam int DIST_W      = 7;

    typedef enum logic [1:0] {
        KIND_REF    = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [SYM_W-1:0] symbol;
    } t_in_word;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_out_word;

    // Wavefront control handed from cell to cell
    typedef struct packed {
        logic             query;
        logic             finish;
        logic [SYM_W-1:0] sym;
    } t_wave_ctl;

endpackage

// File: src/ede_cell.sv
// One cell of the systolic row: holds one reference symbol and one row entry.
// Depends on ede_pkg for the wavefront control struct.
module ede_cell
    import ede_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int J       = 1,
    localparam int CW     = $clog2(MAX_LEN + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_load,
    input  logic [CW-1:0]    i_ref_len,
    input  logic [SYM_W-1:0] i_ref_sym,
    input  t_wave_ctl        i_ctl,
    input  logic [CW-1:0]    i_left,
    input  logic [CW-1:0]    i_diag,
    input  logic [CW-1:0]    i_result,
    output t_wave_ctl        o_ctl,
    output logic [CW-1:0]    o_left,
    output logic [CW-1:0]    o_diag,
    output logic [CW-1:0]    o_result
);

    localparam logic [CW-1:0] POS      = CW'(J);
    localparam logic [CW-1:0] POS_PREV = CW'(J - 1);

    logic [SYM_W-1:0] r_sym;
    logic [CW-1:0]    r_cost;
    t_wave_ctl        r_ctl;
    logic [CW-1:0]    r_left;
    logic [CW-1:0]    r_diag;
    logic [CW-1:0]    r_result;

    logic [CW-1:0] w_min_a;
    logic [CW-1:0] w_min;
    logic [CW-1:0] n_cost;

    // Compute the new entry from left, diagonal and up
    always_comb begin
        w_min_a = (i_left < r_cost) ? i_left : r_cost;
        w_min   = (i_diag < w_min_a) ? i_diag : w_min_a;
        if (r_sym == i_ctl.sym) begin
            n_cost = i_diag;
        end else begin
            n_cost = w_min + CW'(1);
        end
    end

    // Capture the reference symbol when this cell is the next free slot
    always_ff @(posedge i_clk) begin
        if (i_load && (i_ref_len == POS_PREV)) begin
            r_sym <= i_ref_sym;
        end
    end

    // Hold the row entry; restore it to its column index on reset or clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cost <= POS;
        end else if (i_ctl.query) begin
            r_cost <= n_cost;
        end
    end

    // Advance the wavefront to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_cost;
        r_diag   <= r_cost;
        r_result <= (i_ctl.finish && (i_ref_len == POS)) ? r_cost : i_result;
    end

    assign o_ctl    = r_ctl;
    assign o_left   = r_left;
    assign o_diag   = r_diag;
    assign o_result = r_result;

endmodule

// File: src/edit_distance_engine_core.sv
// Top level of the edit distance engine: control, row head and cell chain.
// Depends on ede_pkg and ede_cell.
//
// Reference symbols and query symbols are each taken one per cycle: busy stays
// low while symbols stream in, and each query symbol moves as a skewed
// wavefront along a row of MAX_LEN cells, one cell per cycle. A finish word
// travels behind the last query through the whole row, so busy stays high
// until that word has left the last cell; the result is then driven with
// o_valid for exactly one cycle, in the same cycle in which busy drops, and
// the block is cleared for the next pair. The receiver cannot stall: a result
// must be taken in the cycle it is shown.
module edit_distance_engine_core
    import ede_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_in,
    output logic      o_valid,
    output t_out_word o_out
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int XW = (CW > DIST_W) ? CW : DIST_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_LEN);

    logic          r_busy;
    logic [CW-1:0] r_qlen;
    logic [CW-1:0] r_ref_len;
    logic          r_trunc;
    logic          r_valid;
    t_out_word     r_out;

    logic          w_accept;
    logic          w_load;
    logic          w_clear;
    logic [XW-1:0] w_dist_x;

    t_wave_ctl     w_ctl    [0:MAX_LEN];
    logic [CW-1:0] w_left   [0:MAX_LEN];
    logic [CW-1:0] w_diag   [0:MAX_LEN];
    logic [CW-1:0] w_result [0:MAX_LEN];

    assign w_accept = start && !r_busy;
    assign w_load   = w_accept && (i_in.kind == KIND_REF) && (r_qlen == '0)
                      && (r_ref_len != MAX_C);
    assign w_clear  = w_ctl[MAX_LEN].finish;

    // Drive the row head: entry zero is the query count
    always_comb begin
        w_ctl[0].query  = w_accept && (i_in.kind == KIND_QUERY) && (r_qlen != MAX_C);
        w_ctl[0].finish = w_accept && (i_in.kind == KIND_FINISH);
        w_ctl[0].sym    = i_in.symbol;
        w_left[0]       = r_qlen + CW'(1);
        w_diag[0]       = r_qlen;
        w_result[0]     = r_qlen;
    end

    // Build the row of cells
    for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
        ede_cell #(
            .MAX_LEN (MAX_LEN),
            .J       (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (w_clear),
            .i_load    (w_load),
            .i_ref_len (r_ref_len),
            .i_ref_sym (i_in.symbol),
            .i_ctl     (w_ctl[g-1]),
            .i_left    (w_left[g-1]),
            .i_diag    (w_diag[g-1]),
            .i_result  (w_result[g-1]),
            .o_ctl     (w_ctl[g]),
            .o_left    (w_left[g]),
            .o_diag    (w_diag[g]),
            .o_result  (w_result[g])
        );
    end

    // Track lengths, truncation and busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_busy    <= 1'b0;
            r_qlen    <= '0;
            r_ref_len <= '0;
            r_trunc   <= 1'b0;
        end else if (w_accept) begin
            case (i_in.kind)
                KIND_REF: begin
                    if (r_qlen == '0) begin
                        if (r_ref_len == MAX_C) begin
                            r_trunc <= 1'b1;
                        end else begin
                            r_ref_len <= r_ref_len + CW'(1);
                        end
                    end
                end
                KIND_QUERY: begin
                    if (r_qlen == MAX_C) begin
                        r_trunc <= 1'b1;
                    end else begin
                        r_qlen <= r_qlen + CW'(1);
                    end
                end
                KIND_FINISH: begin
                    r_busy <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Strobe the result word for one cycle
    assign w_dist_x = XW'(w_result[MAX_LEN]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            r_out.distance <= w_dist_x[DIST_W-1:0];
            r_out.overflow <= r_trunc;
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_valid;
    assign o_out   = r_out;

    // Checks
    a_fall_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_valid)
        else $error("busy dropped without a result");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held longer than one cycle");

    a_tail_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[MAX_LEN].finish |-> r_busy)
        else $error("finish word left the row while idle");

    a_no_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !w_ctl[0].query && !w_load)
        else $error("symbol taken while finishing");

endmodule
